// ----- design/gsok_pkg.sv -----
// ----------------------------------------------------------------------------
// gsok_pkg: shared types and constants of the glyph shade/outline kernel
// Command codes, register indexes, sequencer states and shade quantizer.
// ----------------------------------------------------------------------------
package gsok_pkg;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHADOW_RADIUS = 2'd2;

  localparam int unsigned ShadeDiv    = 28;
  localparam int unsigned ShadeLevels = 9;
  localparam logic [7:0]  OUTLINE_LEVEL = 8'd63;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_CENTER = 4'b0010,
    S_SEARCH = 4'b0100,
    S_DRAIN  = 4'b1000
  } state_e;

  // which way a probe steps from the center pixel
  typedef struct packed {
    logic neg_x;
    logic pos_x;
    logic neg_y;
    logic pos_y;
  } dir_t;

  // probe order per radius: four diagonals, then left, right, up, down
  function automatic dir_t dir_offset(logic [2:0] d);
    dir_t o;
    o = '0;
    case (d)
      3'd0: begin o.neg_x = 1'b1; o.neg_y = 1'b1; end
      3'd1: begin o.neg_x = 1'b1; o.pos_y = 1'b1; end
      3'd2: begin o.pos_x = 1'b1; o.neg_y = 1'b1; end
      3'd3: begin o.pos_x = 1'b1; o.pos_y = 1'b1; end
      3'd4: o.neg_x = 1'b1;
      3'd5: o.pos_x = 1'b1;
      3'd6: o.neg_y = 1'b1;
      3'd7: o.pos_y = 1'b1;
      default: o = '0;
    endcase
    return o;
  endfunction

  // intensity / 28 as a count of thresholds passed
  function automatic logic [3:0] shade_code(logic [7:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int k = 1; k <= ShadeLevels; k++) begin
      if (9'(v) >= 9'(k * ShadeDiv)) n = n + 4'd1;
    end
    return n;
  endfunction

endpackage

// ----- design/gsok_pixel_ram.sv -----
// ----------------------------------------------------------------------------
// gsok_pixel_ram: pixel store
// Single-port synchronous RAM, 8-bit entries, registered read data.
// ----------------------------------------------------------------------------
module gsok_pixel_ram #(
  parameter int unsigned DEPTH = 16384,
  parameter int unsigned AW    = 14
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic          we_i,
  input  logic [AW-1:0] addr_i,
  input  logic [7:0]    wdata_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/glyph_shade_outline_kernel.sv -----
// ----------------------------------------------------------------------------
// glyph_shade_outline_kernel: glyph shade and outline lookup
// Stores an 8-bit glyph bitmap; reads return a shade code or an outline mark
// found by a star search of the neighbors in the pixel RAM.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                      Payload
// command   in         start_i & !busy_o              command_i col_i row_i intensity_i
// result    out        result_valid_o, one cycle      shade_o is_blank_o
// config    in         cfg_we_i                       cfg_idx_i cfg_wdata_i
//
// A write, or a read outside the image, is taken in idle; busy_o stays low.
// A read inside the image holds busy_o while the center pixel, then its
// neighbors out to the effective shadow radius, take one RAM probe a cycle; a
// shaded pixel or an early hit ends it sooner; the result strobe comes as busy_o falls.
// Reset clears control and config registers only; pixel RAM is not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module glyph_shade_outline_kernel #(
  parameter int unsigned MAX_WIDTH  = 128,
  parameter int unsigned MAX_HEIGHT = 128,
  parameter int unsigned MAX_RADIUS = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic                         command_i,
  input  logic [6:0]                   col_i,
  input  logic [6:0]                   row_i,
  input  logic [7:0]                   intensity_i,
  output logic                         result_valid_o,
  output logic [3:0]                   shade_o,
  output logic                         is_blank_o,
  input  logic                         cfg_we_i,
  input  logic [gsok_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [7:0]                   cfg_wdata_i
);
  import gsok_pkg::*;

  localparam int unsigned Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned RW    = $clog2(MAX_RADIUS + 1);

  function automatic logic [AW-1:0] pix_addr(logic [6:0] c, logic [6:0] r);
    return AW'(r) * AW'(MAX_WIDTH) + AW'(c);
  endfunction

  state_e         state_q, state_d;
  logic [7:0]     gw_q, gw_d, gh_q, gh_d;
  logic [3:0]     rad_q, rad_d;
  logic [6:0]     x_q, x_d, y_q, y_d;
  logic [RW-1:0]  r_q, r_d;
  logic [2:0]     d_q, d_d;
  logic           pvld_q, pvld_d;
  logic           res_vld_q, res_vld_d;
  logic [3:0]     res_shade_q, res_shade_d;
  logic           res_blank_q, res_blank_d;

  logic           ram_en, ram_we;
  logic [AW-1:0]  ram_addr;
  logic [7:0]     ram_rdata;

  logic [7:0]     ew, eh;
  logic [RW-1:0]  rmax;
  logic           accept, inside_in, bright;
  logic [3:0]     code;
  dir_t           off;
  logic [8:0]     x9, y9, r9, nx9, ny9;
  logic           left, right, up, down, inb;

  // clamp config to the built array size
  assign ew   = (32'(gw_q) > MAX_WIDTH)  ? 8'(MAX_WIDTH)   : gw_q;
  assign eh   = (32'(gh_q) > MAX_HEIGHT) ? 8'(MAX_HEIGHT)  : gh_q;
  assign rmax = (32'(rad_q) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(rad_q);

  assign busy_o    = (state_q != S_IDLE);
  assign accept    = start_i && !busy_o;
  assign inside_in = ({1'b0, col_i} < ew) && ({1'b0, row_i} < eh);
  assign bright    = ram_rdata > OUTLINE_LEVEL;
  assign code      = shade_code(ram_rdata);

  // neighbor probe geometry
  assign off   = dir_offset(d_q);
  assign x9    = 9'(x_q);
  assign y9    = 9'(y_q);
  assign r9    = 9'(r_q);
  assign left  = x9 >= r9;
  assign right = (x9 + r9) < 9'(ew);
  assign up    = y9 >= r9;
  assign down  = (y9 + r9) < 9'(eh);
  assign inb   = (!off.neg_x || left) && (!off.pos_x || right) &&
                 (!off.neg_y || up)   && (!off.pos_y || down);
  assign nx9   = off.neg_x ? (x9 - r9) : (off.pos_x ? (x9 + r9) : x9);
  assign ny9   = off.neg_y ? (y9 - r9) : (off.pos_y ? (y9 + r9) : y9);

  always_comb begin
    gw_d  = gw_q;
    gh_d  = gh_q;
    rad_d = rad_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_GLYPH_WIDTH:   gw_d  = cfg_wdata_i;
        REG_GLYPH_HEIGHT:  gh_d  = cfg_wdata_i;
        REG_SHADOW_RADIUS: rad_d = cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    x_d         = x_q;
    y_d         = y_q;
    r_d         = r_q;
    d_d         = d_q;
    pvld_d      = 1'b0;
    res_vld_d   = 1'b0;
    res_shade_d = res_shade_q;
    res_blank_d = res_blank_q;
    ram_en      = 1'b0;
    ram_we      = 1'b0;
    ram_addr    = pix_addr(col_i, row_i);
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (command_i == CMD_WRITE) begin
            ram_en = inside_in;
            ram_we = 1'b1;
          end else if (inside_in) begin
            ram_en  = 1'b1;
            x_d     = col_i;
            y_d     = row_i;
            state_d = S_CENTER;
          end else begin
            res_vld_d   = 1'b1;
            res_shade_d = 4'd0;
            res_blank_d = 1'b1;
          end
        end
      end
      S_CENTER: begin
        if (code != 4'd0 || rmax == '0) begin
          res_vld_d   = 1'b1;
          res_shade_d = code;
          res_blank_d = (code == 4'd0);
          state_d     = S_IDLE;
        end else begin
          r_d     = RW'(1);
          d_d     = 3'd0;
          state_d = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (pvld_q && bright) begin
          res_vld_d   = 1'b1;
          res_shade_d = 4'd0;
          res_blank_d = 1'b0;
          state_d     = S_IDLE;
        end else begin
          ram_en   = inb;
          ram_addr = pix_addr(nx9[6:0], ny9[6:0]);
          pvld_d   = inb;
          d_d      = d_q + 3'd1;
          if (d_q == 3'd7) begin
            if (r_q == rmax) state_d = S_DRAIN;
            else             r_d = r_q + RW'(1);
          end
        end
      end
      S_DRAIN: begin
        res_vld_d   = 1'b1;
        res_shade_d = 4'd0;
        res_blank_d = !(pvld_q && bright);
        state_d     = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      gw_q      <= 8'd128;
      gh_q      <= 8'd128;
      rad_q     <= 4'd1;
      pvld_q    <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      gw_q      <= gw_d;
      gh_q      <= gh_d;
      rad_q     <= rad_d;
      pvld_q    <= pvld_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q         <= x_d;
    y_q         <= y_d;
    r_q         <= r_d;
    d_q         <= d_d;
    res_shade_q <= res_shade_d;
    res_blank_q <= res_blank_d;
  end

  gsok_pixel_ram #(
    .DEPTH(Depth),
    .AW   (AW)
  ) u_ram (
    .clk_i  (clk_i),
    .en_i   (ram_en),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(intensity_i),
    .rdata_o(ram_rdata)
  );

  assign result_valid_o = res_vld_q;
  assign shade_o        = res_shade_q;
  assign is_blank_o     = res_blank_q;

endmodule

// ----- design/gsok_checker.sv -----
// ----------------------------------------------------------------------------
// gsok_port_checks: port-level checks of the glyph shade/outline kernel
// Watches command and result ports; bound to the top level.
// ----------------------------------------------------------------------------
module gsok_port_checks (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic       command_i,
  input logic       result_valid_o,
  input logic [3:0] shade_o,
  input logic       is_blank_o
);
  import gsok_pkg::*;

  // a write item never yields a result
  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && command_i == CMD_WRITE) |=> !result_valid_o)
    else $error("result after write item");

  // a read item answers at once or starts a search
  a_read_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && command_i == CMD_READ) |=> (result_valid_o || busy_o))
    else $error("read item dropped");

  // results only follow an accepted item or a running search
  a_result_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ($past(start_i && !busy_o) || $past(busy_o)))
    else $error("result without item");

  // a shade code is never blank and never exceeds nine
  a_shade_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && shade_o != 4'd0) |-> (!is_blank_o && shade_o <= 4'd9))
    else $error("bad shade result");

endmodule

bind glyph_shade_outline_kernel gsok_port_checks u_gsok_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .command_i     (command_i),
  .result_valid_o(result_valid_o),
  .shade_o       (shade_o),
  .is_blank_o    (is_blank_o)
);

// ----- tb/gsok_checker.sv -----
// ----------------------------------------------------------------------------
// gsok_checker: scoreboard for the glyph shade/outline kernel
// Tracks register writes and accepted items. It keeps a shadow copy of the
// pixel store and predicts the shade or outline code of every read, then
// compares each result strobe, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module gsok_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic                           busy_i,
  input  logic                           command_i,
  input  logic [6:0]                     col_i,
  input  logic [6:0]                     row_i,
  input  logic [7:0]                     intensity_i,
  input  logic                           result_valid_i,
  input  logic [3:0]                     shade_i,
  input  logic                           is_blank_i,
  input  logic                           cfg_we_i,
  input  logic [gsok_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [7:0]                     cfg_wdata_i,
  output int unsigned                    mismatch_count_o,
  output int unsigned                    pending_o
);

  localparam int unsigned MAX_SIDE     = 128;
  localparam int unsigned MAX_REACH    = 8;
  localparam int unsigned SHADE_STEP   = 28;
  localparam int unsigned BRIGHT_LEVEL = 63;

  typedef struct packed {
    logic [3:0] shade;
    logic       blank;
  } shade_result_t;

  logic [7:0]    pixel_mem [0:MAX_SIDE*MAX_SIDE-1];
  logic [7:0]    width_q;
  logic [7:0]    height_q;
  logic [3:0]    radius_q;
  shade_result_t shade_q [$];
  int unsigned   mismatches;

  function automatic int unsigned clamp_side(logic [7:0] v);
    return (v > MAX_SIDE) ? MAX_SIDE : v;
  endfunction

  // shade code of a read, or a star search for a bright neighbor
  function automatic shade_result_t shade_lookup(logic [6:0] c, logic [6:0] r);
    int            wd;
    int            ht;
    int            reach;
    int            nx;
    int            ny;
    logic [3:0]    code;
    shade_result_t res;
    wd    = clamp_side(width_q);
    ht    = clamp_side(height_q);
    reach = (radius_q > MAX_REACH) ? MAX_REACH : radius_q;
    res   = '{shade: 4'd0, blank: 1'b1};
    if (int'(c) >= wd || int'(r) >= ht) return res;
    code = 4'(pixel_mem[{r, c}] / SHADE_STEP);
    if (code != 4'd0) begin
      res.shade = code;
      res.blank = 1'b0;
      return res;
    end
    for (int k = 1; k <= reach; k++) begin
      for (int dx = -1; dx <= 1; dx++) begin
        for (int dy = -1; dy <= 1; dy++) begin
          nx = int'(c) + dx * k;
          ny = int'(r) + dy * k;
          if ((dx != 0 || dy != 0) && nx >= 0 && nx < wd && ny >= 0 && ny < ht &&
              pixel_mem[ny * MAX_SIDE + nx] > BRIGHT_LEVEL)
            res.blank = 1'b0;
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    shade_result_t got;
    shade_result_t want;
    if (!rst_ni) begin
      width_q          <= 8'd128;
      height_q         <= 8'd128;
      radius_q         <= 4'd1;
      shade_q.delete();
      mismatches       = 0;
      mismatch_count_o <= 0;
      pending_o        <= 0;
    end else begin
      if (result_valid_i) begin
        got = '{shade: shade_i, blank: is_blank_i};
        if (shade_q.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected result shade %0d blank %0b",
                     $realtime, got.shade, got.blank);
          mismatches++;
        end else begin
          want = shade_q.pop_front();
          if (got.shade !== want.shade || got.blank !== want.blank) begin
            if (mismatches < 10)
              $display("%0t: mismatch, expected shade %0d blank %0b, got shade %0d blank %0b",
                       $realtime, want.shade, want.blank, got.shade, got.blank);
            mismatches++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          gsok_pkg::REG_GLYPH_WIDTH:   width_q  <= cfg_wdata_i;
          gsok_pkg::REG_GLYPH_HEIGHT:  height_q <= cfg_wdata_i;
          gsok_pkg::REG_SHADOW_RADIUS: radius_q <= cfg_wdata_i[3:0];
          default: ;
        endcase
      end
      if (start_i && !busy_i) begin
        if (command_i == gsok_pkg::CMD_READ)
          shade_q.push_back(shade_lookup(col_i, row_i));
        else if (col_i < clamp_side(width_q) && row_i < clamp_side(height_q))
          pixel_mem[{row_i, col_i}] = intensity_i;
      end
      mismatch_count_o <= mismatches;
      pending_o        <= shade_q.size();
    end
  end

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: testbench for the glyph shade/outline kernel
// Fills a corner window of the pixel store, runs a directed set of shade and
// outline cases, then random writes and reads over a series of image sizes
// and search radii, with random sender gaps. The checker predicts every result.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned STALL_LIMIT     = 4000;
  localparam int unsigned DRAIN_CYCLES    = 70;
  localparam int unsigned PHASES          = 12;
  localparam int unsigned FIXED_PHASES    = 8;
  localparam int unsigned ITEMS_PER_PHASE = 85;
  // written window, and the read range whose whole star stays inside it
  localparam int unsigned FILL_SIDE       = 24;
  localparam int unsigned READ_SIDE       = 16;
  localparam logic [gsok_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           start;
  logic                           busy;
  logic                           command;
  logic [6:0]                     col;
  logic [6:0]                     row;
  logic [7:0]                     intensity;
  logic                           result_valid;
  logic [3:0]                     shade;
  logic                           is_blank;
  logic                           cfg_we;
  logic [gsok_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [7:0]                     cfg_wdata;
  int unsigned                    mismatches;
  int unsigned                    pending;
  int unsigned                    stall_cycles = 0;

  // width, height, radius of the fixed phases: extremes, empty and oversized
  logic [7:0] phase_w [FIXED_PHASES] = '{8'd128, 8'd1, 8'd128, 8'd1, 8'd0, 8'd255, 8'd16, 8'd60};
  logic [7:0] phase_h [FIXED_PHASES] = '{8'd128, 8'd1, 8'd1, 8'd128, 8'd40, 8'd200, 8'd16, 8'd0};
  logic [3:0] phase_r [FIXED_PHASES] = '{4'd8, 4'd1, 4'd3, 4'd5, 4'd2, 4'd15, 4'd0, 4'd4};

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  glyph_shade_outline_kernel u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start),
    .busy_o         (busy),
    .command_i      (command),
    .col_i          (col),
    .row_i          (row),
    .intensity_i    (intensity),
    .result_valid_o (result_valid),
    .shade_o        (shade),
    .is_blank_o     (is_blank),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata)
  );

  gsok_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .start_i          (start),
    .busy_i           (busy),
    .command_i        (command),
    .col_i            (col),
    .row_i            (row),
    .intensity_i      (intensity),
    .result_valid_i   (result_valid),
    .shade_i          (shade),
    .is_blank_i       (is_blank),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  // watchdog: cycles with no item, result or register write
  always @(posedge clk) begin
    if ((start && !busy) || result_valid || cfg_we) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic [7:0] level_draw(int unsigned bright_pct);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < bright_pct) return 8'($urandom_range(64, 255));
    if (roll < bright_pct + 25) return 8'($urandom_range(28, 63));
    return 8'($urandom_range(0, 27));
  endfunction

  // start stays high across back-to-back items; lowered only for a gap
  task automatic send_item(input logic cmd, input logic [6:0] c, input logic [6:0] r,
                           input logic [7:0] v, input int unsigned gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    command   <= cmd;
    col       <= c;
    row       <= r;
    intensity <= v;
    do @(posedge clk); while (busy);
  endtask

  // wait out all results, then the longest search the block could still run
  task automatic drain_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] w, input logic [7:0] h, input logic [3:0] rad);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_SPARE;
    cfg_wdata <= 8'($urandom);
    @(posedge clk);
    cfg_idx   <= gsok_pkg::REG_GLYPH_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_idx   <= gsok_pkg::REG_GLYPH_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_idx   <= gsok_pkg::REG_SHADOW_RADIUS;
    cfg_wdata <= {4'($urandom), rad};
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin : stimulus
    logic [7:0]  w;
    logic [7:0]  h;
    logic [3:0]  rad;
    int unsigned span_w;
    int unsigned span_h;
    int unsigned lim_w;
    int unsigned lim_h;
    logic        cmd;
    logic [6:0]  c;
    logic [6:0]  r;
    bit          burst;

    rst_n     <= 1'b0;
    start     <= 1'b0;
    command   <= gsok_pkg::CMD_WRITE;
    col       <= '0;
    row       <= '0;
    intensity <= '0;
    cfg_we    <= 1'b0;
    cfg_idx   <= gsok_pkg::REG_GLYPH_WIDTH;
    cfg_wdata <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corner window written once; reads and their stars stay inside it;
    // sparse bright pixels leave room for blank reads at large radii
    for (int i = 0; i < FILL_SIDE; i++)
      for (int j = 0; j < FILL_SIDE; j++)
        send_item(gsok_pkg::CMD_WRITE, 7'(j), 7'(i), level_draw(3), 0);

    // 2x2 blocks at the other three image corners
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 2; j++) begin
        send_item(gsok_pkg::CMD_WRITE, 7'(126 + i), 7'(j), level_draw(3), 0);
        send_item(gsok_pkg::CMD_WRITE, 7'(i), 7'(126 + j), level_draw(3), 0);
        send_item(gsok_pkg::CMD_WRITE, 7'(126 + i), 7'(126 + j), level_draw(3), 0);
      end

    // directed items at reset settings (128 x 128, radius 1)
    send_item(gsok_pkg::CMD_WRITE, 7'd0, 7'd0, 8'd255, 0);
    send_item(gsok_pkg::CMD_READ, 7'd0, 7'd0, 8'h00, 0);
    send_item(gsok_pkg::CMD_WRITE, 7'd127, 7'd0, 8'd252, $urandom_range(0, 10));
    send_item(gsok_pkg::CMD_READ, 7'd127, 7'd0, 8'hFF, 0);
    send_item(gsok_pkg::CMD_WRITE, 7'd0, 7'd127, 8'd251, $urandom_range(0, 10));
    send_item(gsok_pkg::CMD_READ, 7'd0, 7'd127, 8'h55, 0);
    send_item(gsok_pkg::CMD_WRITE, 7'd127, 7'd127, 8'd0, 0);
    send_item(gsok_pkg::CMD_READ, 7'd127, 7'd127, 8'hAA, $urandom_range(0, 10));
    send_item(gsok_pkg::CMD_WRITE, 7'd5, 7'd5, 8'd28, 0);
    send_item(gsok_pkg::CMD_READ, 7'd5, 7'd5, 8'h00, 0);
    // dark 3x3 patch: blank, then a neighbor at the threshold, then just above
    for (int i = 20; i <= 22; i++)
      for (int j = 20; j <= 22; j++)
        send_item(gsok_pkg::CMD_WRITE, 7'(i), 7'(j), 8'd27, 0);
    send_item(gsok_pkg::CMD_READ, 7'd21, 7'd21, 8'h00, $urandom_range(0, 10));
    send_item(gsok_pkg::CMD_WRITE, 7'd22, 7'd21, 8'd63, 0);
    send_item(gsok_pkg::CMD_READ, 7'd21, 7'd21, 8'h00, 0);
    send_item(gsok_pkg::CMD_WRITE, 7'd22, 7'd21, 8'd64, $urandom_range(0, 10));
    send_item(gsok_pkg::CMD_READ, 7'd21, 7'd21, 8'hFF, 0);

    for (int p = 0; p < PHASES; p++) begin
      if (p < FIXED_PHASES) begin
        w   = phase_w[p];
        h   = phase_h[p];
        rad = phase_r[p];
      end else begin
        w   = 8'($urandom_range(1, 128));
        h   = 8'($urandom_range(1, 128));
        rad = 4'($urandom_range(1, 8));
      end
      span_w = (w > 128) ? 128 : w;
      span_h = (h > 128) ? 128 : h;
      lim_w  = (span_w > FILL_SIDE) ? READ_SIDE : span_w;
      lim_h  = (span_h > FILL_SIDE) ? READ_SIDE : span_h;
      drain_idle();
      set_config(w, h, rad);
      burst = 1'b0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(0, 19) == 0) burst = !burst;
        // occasional full stop until every read has answered
        if ($urandom_range(0, 49) == 0) begin
          start <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
        cmd = ($urandom_range(0, 99) < 55) ? gsok_pkg::CMD_READ : gsok_pkg::CMD_WRITE;
        if (span_w == 0 || $urandom_range(0, 99) < 12) c = 7'($urandom);
        else c = 7'($urandom_range(0, lim_w - 1));
        if (span_h == 0 || $urandom_range(0, 99) < 12) r = 7'($urandom);
        else r = 7'($urandom_range(0, lim_h - 1));
        // a read inside the image is kept where its whole star was written
        if (cmd == gsok_pkg::CMD_READ && c < span_w && r < span_h &&
            (c >= lim_w || r >= lim_h)) begin
          c = 7'($urandom_range(0, lim_w - 1));
          r = 7'($urandom_range(0, lim_h - 1));
        end
        send_item(cmd, c, r, level_draw(25), burst ? 0 : $urandom_range(0, 10));
      end
    end

    drain_idle();
    if (mismatches == 0 && pending == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
